// File: rtl/core/rhpq_pkg.sv
// Shared types and constants for the RGB hue palette quantizer.
// Holds the beat structs, the match kind codes and the palette hue table.
// Depends on nothing; every other file in rtl/core uses it.
package rhpq_pkg;

	// Palette geometry.
	localparam int PALETTE_SIZE = 9;
	localparam int IDX_W        = 4;
	localparam int CODE_W       = 7;
	localparam int PALETTE_W    = PALETTE_SIZE * CODE_W;

	// Hue numerator scaled by 60 stays below 360*255, so 17 bits cover it.
	localparam int HUE_W   = 17;
	localparam int DELTA_W = 8;

	// Palette hues in degrees, in palette order.
	localparam logic [8:0] PALETTE_HUE [PALETTE_SIZE] = '{
		9'd0, 9'd30, 9'd55, 9'd120, 9'd180, 9'd235, 9'd280, 9'd325, 9'd305
	};

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_PALETTE = 1'b0,
		REG_WHITE   = 1'b1
	} reg_index_t;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_HUE     = 2'd0,
		KIND_WHITE   = 2'd1,
		KIND_INVALID = 2'd2
	} kind_t;

	// Input beat.
	typedef struct packed {
		logic [23:0] rgb_value;
		logic        colour_valid;
	} in_beat_t;

	// Result beat.
	typedef struct packed {
		logic [CODE_W-1:0] pad_code;
		logic [1:0]        match_kind;
	} out_beat_t;

	// Token handed from cell to cell along the chain.
	typedef struct packed {
		kind_t              kind;
		logic [HUE_W-1:0]   hue_num;
		logic [DELTA_W-1:0] delta;
		logic [HUE_W-1:0]   best_dist;
		logic [IDX_W-1:0]   best_idx;
	} token_t;

endpackage

// File: rtl/core/rhpq_front.sv
// Front stage of the quantizer: max, min, delta, grey test and hue numerator.
// Produces the first chain token in a register. Depends on rhpq_pkg.
module rhpq_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  rhpq_pkg::in_beat_t in_beat,
	output logic               in_ready,
	output logic               out_valid,
	output rhpq_pkg::token_t   out_tok,
	input  logic               out_ready
);

	logic [7:0]  r, g, b;
	logic [7:0]  mx, mn, d;
	logic [14:0] sat_lhs, sat_rhs;
	logic [11:0] n_signed;
	logic [10:0] n_val;
	rhpq_pkg::token_t tok;
	logic        valid_q;
	rhpq_pkg::token_t tok_q;

	assign r = in_beat.rgb_value[23:16];
	assign g = in_beat.rgb_value[15:8];
	assign b = in_beat.rgb_value[7:0];

	// Spread of the three channels.
	always_comb begin
		mx = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		sat_lhs = 15'(d) * 15'd100;
		sat_rhs = 15'(mx) * 15'd18;
	end

	// Hue numerator, red tested first, then green.
	always_comb begin
		if (mx == r) begin
			n_signed = 12'(g) - 12'(b);
			if (n_signed[11]) n_signed = n_signed + 12'(d) * 12'd6;
		end else if (mx == g) begin
			n_signed = 12'(b) - 12'(r) + 12'(d) * 12'd2;
		end else begin
			n_signed = 12'(r) - 12'(g) + 12'(d) * 12'd4;
		end
		n_val = n_signed[10:0];
	end

	// Build the token that enters the first hue cell.
	always_comb begin
		tok.hue_num   = rhpq_pkg::HUE_W'(n_val) * rhpq_pkg::HUE_W'(60);
		tok.delta     = d;
		tok.best_dist = rhpq_pkg::HUE_W'(d) * rhpq_pkg::HUE_W'(361);
		tok.best_idx  = '0;
		if (!in_beat.colour_valid) begin
			tok.kind = rhpq_pkg::KIND_INVALID;
		end else if (d == 8'd0 || sat_lhs < sat_rhs) begin
			tok.kind = rhpq_pkg::KIND_WHITE;
		end else begin
			tok.kind = rhpq_pkg::KIND_HUE;
		end
	end

	assign in_ready = !valid_q || out_ready;

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tok_q <= tok;
		end
	end

	assign out_valid = valid_q;
	assign out_tok   = tok_q;

endmodule

// File: rtl/core/rhpq_cell.sv
// One hue cell of the chain: circular distance to one palette hue, keep the best.
// Identical cells differ only by the hue and index on their ports. Depends on rhpq_pkg.
module rhpq_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [8:0]                 hue,
	input  logic [rhpq_pkg::IDX_W-1:0] index,
	input  logic                       in_valid,
	input  rhpq_pkg::token_t           in_tok,
	output logic                       in_ready,
	output logic                       out_valid,
	output rhpq_pkg::token_t           out_tok,
	input  logic                       out_ready
);

	logic [rhpq_pkg::HUE_W-1:0] target, full_turn, diff, alt, near_dist;
	rhpq_pkg::token_t tok;
	logic             valid_q;
	rhpq_pkg::token_t tok_q;

	// Distances are all scaled by delta, so the compare is exact.
	always_comb begin
		target    = rhpq_pkg::HUE_W'(hue) * rhpq_pkg::HUE_W'(in_tok.delta);
		full_turn = rhpq_pkg::HUE_W'(in_tok.delta) * rhpq_pkg::HUE_W'(360);
		if (in_tok.hue_num >= target) begin
			diff = in_tok.hue_num - target;
		end else begin
			diff = target - in_tok.hue_num;
		end
		alt       = full_turn - diff;
		near_dist = (alt < diff) ? alt : diff;
		tok       = in_tok;
		// Strict compare keeps the earlier entry on a tie.
		if (near_dist < in_tok.best_dist) begin
			tok.best_dist = near_dist;
			tok.best_idx  = index;
		end
	end

	assign in_ready = !valid_q || out_ready;

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tok_q <= tok;
		end
	end

	assign out_valid = valid_q;
	assign out_tok   = tok_q;

endmodule

// File: rtl/core/rhpq_select.sv
// Output stage: turns the final token into a pad code and holds the result beat.
// Reads the configuration registers from the top level. Depends on rhpq_pkg.
module rhpq_select (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [rhpq_pkg::PALETTE_W-1:0] palette,
	input  logic [rhpq_pkg::CODE_W-1:0]    white,
	input  logic                           in_valid,
	input  rhpq_pkg::token_t               in_tok,
	output logic                           in_ready,
	output logic                           out_valid,
	output rhpq_pkg::out_beat_t            out_beat,
	input  logic                           out_stall
);

	logic [rhpq_pkg::CODE_W-1:0] hue_code;
	rhpq_pkg::out_beat_t         beat;
	logic                        valid_q;
	rhpq_pkg::out_beat_t         beat_q;

	// Palette entry chosen by the chain.
	always_comb begin
		hue_code = palette[rhpq_pkg::CODE_W-1:0];
		for (int i = 0; i < rhpq_pkg::PALETTE_SIZE; i++) begin
			if (in_tok.best_idx == rhpq_pkg::IDX_W'(i)) begin
				hue_code = palette[i*rhpq_pkg::CODE_W +: rhpq_pkg::CODE_W];
			end
		end
	end

	// Result code by kind.
	always_comb begin
		beat.match_kind = in_tok.kind;
		unique case (in_tok.kind)
			rhpq_pkg::KIND_INVALID: beat.pad_code = palette[rhpq_pkg::CODE_W-1:0];
			rhpq_pkg::KIND_WHITE:   beat.pad_code = white;
			default:                beat.pad_code = hue_code;
		endcase
	end

	assign in_ready = !valid_q || !out_stall;

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_q <= beat;
		end
	end

	assign out_valid = valid_q;
	assign out_beat  = beat_q;

endmodule

// File: rtl/core/rgb_hue_palette_quantizer_core.sv
// Top level of the RGB hue palette quantizer: configuration registers and the cell chain.
// Instantiates rhpq_front, nine rhpq_cell and rhpq_select. Depends on rhpq_pkg.
//
//   Channel   Direction  Handshake           Payload
//   in        input      in_valid/in_stall   in_data (rgb_value, colour_valid)
//   out       output     out_valid/out_stall out_data (pad_code, match_kind)
//   cfg       input      cfg_we              cfg_index, cfg_data
//
// One beat is accepted every cycle while in_stall is low; on its way to the output a beat
// passes through eleven registers: the front stage, the nine hue cells and the output register.
// Every stage has its own valid flag, so an empty stage takes a beat even while the
// output is stalled; in_stall rises only when all eleven stages are full.
// Reset clears the stage valid flags and both configuration registers.
module rgb_hue_palette_quantizer_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  rhpq_pkg::in_beat_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output rhpq_pkg::out_beat_t            out_data,
	input  logic                           cfg_we,
	input  logic [0:0]                     cfg_index,
	input  logic [rhpq_pkg::PALETTE_W-1:0] cfg_data
);

	localparam int N = rhpq_pkg::PALETTE_SIZE;

	logic [rhpq_pkg::PALETTE_W-1:0] palette_q;
	logic [rhpq_pkg::CODE_W-1:0]    white_q;

	logic             link_valid [N+1];
	logic             link_ready [N+1];
	rhpq_pkg::token_t link_tok   [N+1];
	logic             front_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_q <= '0;
			white_q   <= '0;
		end else if (cfg_we) begin
			unique case (rhpq_pkg::reg_index_t'(cfg_index))
				rhpq_pkg::REG_PALETTE: palette_q <= cfg_data;
				rhpq_pkg::REG_WHITE:   white_q   <= cfg_data[rhpq_pkg::CODE_W-1:0];
				default:               ;
			endcase
		end
	end

	rhpq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_beat   (in_data),
		.in_ready  (front_ready),
		.out_valid (link_valid[0]),
		.out_tok   (link_tok[0]),
		.out_ready (link_ready[0])
	);

	assign in_stall = !front_ready;

	// The chain of hue cells, one palette entry each.
	for (genvar i = 0; i < N; i++) begin : g_cell
		rhpq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.hue       (rhpq_pkg::PALETTE_HUE[i]),
			.index     (rhpq_pkg::IDX_W'(i)),
			.in_valid  (link_valid[i]),
			.in_tok    (link_tok[i]),
			.in_ready  (link_ready[i]),
			.out_valid (link_valid[i+1]),
			.out_tok   (link_tok[i+1]),
			.out_ready (link_ready[i+1])
		);
	end

	rhpq_select u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.palette   (palette_q),
		.white     (white_q),
		.in_valid  (link_valid[N]),
		.in_tok    (link_tok[N]),
		.in_ready  (link_ready[N]),
		.out_valid (out_valid),
		.out_beat  (out_data),
		.out_stall (out_stall)
	);

	// An invalid colour always reports the red entry.
	a_invalid_red: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.match_kind == rhpq_pkg::KIND_INVALID)
			|-> out_data.pad_code == palette_q[rhpq_pkg::CODE_W-1:0])
		else $error("invalid colour did not give the red code");

	// A grey colour always reports the white code.
	a_white_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.match_kind == rhpq_pkg::KIND_WHITE)
			|-> out_data.pad_code == white_q)
		else $error("grey colour did not give the white code");

	// The input is held off only when the output is full and stalled.
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while the output could move");

	// A stalled output beat leaves the output stage full in the next cycle.
	a_chain_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled output beat was dropped");

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for rgb_hue_palette_quantizer_core.
// Drives colour beats and palette settings, predicts each pad code and checks every result.
// Depends on rhpq_pkg and the core RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HUE_COUNT    = 9;
	localparam int RESET_CYCLES = 12;
	localparam int PIPE_DEPTH   = 11;
	localparam int HOLD_CYCLES  = 60;
	localparam int CYCLE_LIMIT  = 1000000;

	// Palette hues in degrees, in palette order.
	localparam int HUE_DEG [HUE_COUNT] = '{0, 30, 55, 120, 180, 235, 280, 325, 305};

	// Hand-picked colours: invalid beats, greys, the saturation edge, primaries and hue ties.
	localparam rhpq_pkg::in_beat_t CORNER_BEATS [25] = '{
		'{24'hFFFFFF, 1'b0}, '{24'h000000, 1'b0}, '{24'h12A5C3, 1'b0},
		'{24'h000000, 1'b1}, '{24'hFFFFFF, 1'b1}, '{24'h808080, 1'b1},
		'{24'h645353, 1'b1}, // spread one short of the grey threshold
		'{24'h645252, 1'b1}, // spread exactly at the threshold gives a hue
		'{24'hFF0000, 1'b1}, '{24'h00FF00, 1'b1}, '{24'h0000FF, 1'b1},
		'{24'hFFFF00, 1'b1}, // red and green share the max, red wins
		'{24'h00FFFF, 1'b1}, // green and blue share the max, green wins
		'{24'hFF00FF, 1'b1}, // red and blue share the max, hue wraps
		'{24'hFF8000, 1'b1},
		'{24'hFF0014, 1'b1}, // hue just under 360 lands on red
		'{24'hC83200, 1'b1}, // tie red/orange at 15 degrees
		'{24'hC80096, 1'b1}, // tie magenta/pink at 315 degrees
		'{24'hF00046, 1'b1}, // tie pink/red at 342.5 degrees across the wrap
		'{24'hAA00FF, 1'b1}, // purple at exactly 280 degrees
		'{24'hF0008C, 1'b1}, // pink at exactly 325 degrees
		'{24'h82F000, 1'b1}, // tie yellow/green
		'{24'h0082F0, 1'b1}, // tie cyan/blue
		'{24'h4600F0, 1'b1}, // tie blue/purple
		'{24'h00F078, 1'b1}  // tie green/cyan
	};

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           in_valid  = 1'b0;
	logic                           in_stall;
	rhpq_pkg::in_beat_t             in_data   = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	rhpq_pkg::out_beat_t            out_data;
	logic                           cfg_we    = 1'b0;
	logic [0:0]                     cfg_index = '0;
	logic [rhpq_pkg::PALETTE_W-1:0] cfg_data  = '0;

	// Local copy of the configuration registers.
	logic [rhpq_pkg::PALETTE_W-1:0] palette_now = '0;
	logic [rhpq_pkg::CODE_W-1:0]    white_now   = '0;

	rhpq_pkg::out_beat_t pad_expect_q [$];
	int unsigned mismatches         = 0;
	int unsigned results_checked    = 0;
	int unsigned colours_sent       = 0;
	int unsigned settings_loaded    = 0;
	int unsigned input_stall_cycles = 0;
	int unsigned cycle_count        = 0;

	// Pacing controls shared by the sender, the receiver and the tests.
	logic no_idle = 1'b0;
	logic hold_req = 1'b0;
	logic holding = 1'b0;

	rgb_hue_palette_quantizer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// Pad code predictor. Hue and distances are kept scaled by delta so all compares are exact.
	function automatic rhpq_pkg::out_beat_t predict_pad(input rhpq_pkg::in_beat_t beat);
		int r, g, b, mx, mn, d, n, h, diff, best_dist, best;
		rhpq_pkg::out_beat_t res;
		r = int'(beat.rgb_value[23:16]);
		g = int'(beat.rgb_value[15:8]);
		b = int'(beat.rgb_value[7:0]);
		if (!beat.colour_valid) begin
			res.pad_code   = palette_now[rhpq_pkg::CODE_W-1:0];
			res.match_kind = rhpq_pkg::KIND_INVALID;
			return res;
		end
		mx = (r > g) ? r : g;
		mx = (b > mx) ? b : mx;
		mn = (r < g) ? r : g;
		mn = (b < mn) ? b : mn;
		d  = mx - mn;
		if (d == 0 || 100 * d < 18 * mx) begin
			res.pad_code   = white_now;
			res.match_kind = rhpq_pkg::KIND_WHITE;
			return res;
		end
		// Red is checked first, then green.
		if (mx == r) begin
			n = g - b;
			if (n < 0)
				n += 6 * d;
		end else if (mx == g) begin
			n = b - r + 2 * d;
		end else begin
			n = r - g + 4 * d;
		end
		h = 60 * n;
		// Least circular distance; a strict compare keeps the earlier entry on ties.
		best      = 0;
		best_dist = 361 * d;
		for (int i = 0; i < HUE_COUNT; i++) begin
			diff = h - HUE_DEG[i] * d;
			if (diff < 0)
				diff = -diff;
			if (360 * d - diff < diff)
				diff = 360 * d - diff;
			if (diff < best_dist) begin
				best_dist = diff;
				best      = i;
			end
		end
		res.pad_code   = palette_now[rhpq_pkg::CODE_W*best +: rhpq_pkg::CODE_W];
		res.match_kind = rhpq_pkg::KIND_HUE;
		return res;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int unsigned next_gap();
		int unsigned roll;
		if (no_idle)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// Random colour, weighted toward invalid beats, greys, the grey threshold and tied maxima.
	function automatic rhpq_pkg::in_beat_t random_colour();
		rhpq_pkg::in_beat_t beat;
		int unsigned roll;
		int top, bot, spread, p, q;
		logic [7:0] ch [3];
		roll              = $urandom_range(0, 99);
		beat.rgb_value    = 24'($urandom());
		beat.colour_valid = 1'b1;
		if (roll < 8) begin
			beat.colour_valid = 1'b0;
		end else if (roll < 16) begin
			ch[0]          = 8'($urandom_range(0, 255));
			beat.rgb_value = {3{ch[0]}};
		end else if (roll < 40) begin
			top = $urandom_range(1, 255);
			if (roll < 30)
				spread = (18 * top) / 100 + int'($urandom_range(0, 2)) - 1;
			else
				spread = $urandom_range(1, top);
			if (spread < 0)
				spread = 0;
			bot = top - spread;
			p = $urandom_range(0, 2);
			q = (p + 1 + $urandom_range(0, 1)) % 3;
			ch[p] = 8'(top);
			ch[q] = 8'(bot);
			ch[3 - p - q] = (roll < 30) ? 8'($urandom_range(bot, top)) : 8'(top);
			beat.rgb_value = {ch[0], ch[1], ch[2]};
		end
		return beat;
	endfunction

	// Offer one colour beat, hold it until accepted, then record the expected result.
	task automatic send_colour(input rhpq_pkg::in_beat_t beat);
		int unsigned gap;
		in_valid <= 1'b1;
		in_data  <= beat;
		@(posedge clk);
		while (in_stall) begin
			input_stall_cycles++;
			@(posedge clk);
		end
		pad_expect_q.push_back(predict_pad(beat));
		colours_sent++;
		gap = next_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every expected result has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pad_expect_q.size() != 0)
			@(posedge clk);
	endtask

	// Write both registers back to back. Only called while the block is empty.
	task automatic load_palette(input logic [rhpq_pkg::PALETTE_W-1:0] codes,
			input logic [rhpq_pkg::PALETTE_W-1:0] white_word);
		cfg_we    <= 1'b1;
		cfg_index <= rhpq_pkg::REG_PALETTE;
		cfg_data  <= codes;
		@(posedge clk);
		cfg_index <= rhpq_pkg::REG_WHITE;
		cfg_data  <= white_word;
		@(posedge clk);
		cfg_we      <= 1'b0;
		palette_now = codes;
		white_now   = white_word[rhpq_pkg::CODE_W-1:0];
		settings_loaded++;
	endtask

	task automatic send_random(input int unsigned count);
		repeat (count)
			send_colour(random_colour());
	endtask

	// Registers straight out of reset: every code must read as zero.
	task automatic test_reset_values();
		send_random(20);
		wait_drained();
	endtask

	// Directed colours against a palette of distinct codes.
	task automatic test_corner_colours();
		logic [rhpq_pkg::PALETTE_W-1:0] codes;
		for (int i = 0; i < HUE_COUNT; i++)
			codes[rhpq_pkg::CODE_W*i +: rhpq_pkg::CODE_W] = rhpq_pkg::CODE_W'(13 * i + 5);
		// Upper bits of the white write are junk and must be dropped.
		load_palette(codes, 63'h3A5A5A5A5A5A5A2A);
		foreach (CORNER_BEATS[i])
			send_colour(CORNER_BEATS[i]);
		wait_drained();
	endtask

	// All register bits set.
	task automatic test_saturated_registers();
		load_palette('1, '1);
		send_random(150);
		wait_drained();
	endtask

	// Several random settings, each followed by random traffic.
	task automatic test_random_settings();
		repeat (4) begin
			load_palette(rhpq_pkg::PALETTE_W'({$urandom(), $urandom()}),
				rhpq_pkg::PALETTE_W'({$urandom(), $urandom()}));
			send_random(250);
			wait_drained();
		end
	endtask

	// One beat per cycle with no idling on either side.
	task automatic test_streaming();
		no_idle = 1'b1;
		send_random(100);
		wait_drained();
		no_idle = 1'b0;
	endtask

	// Output held off long enough for the pipeline to fill and stall the input.
	task automatic test_output_hold_off();
		hold_req = 1'b1;
		while (!holding)
			@(posedge clk);
		no_idle = 1'b1;
		send_random(40);
		wait_drained();
		no_idle = 1'b0;
	endtask

	// Receiver pacing: random stall bursts, or one long hold-off when a test asks for it.
	initial begin : sink_pacing
		int unsigned span;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				holding  = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				holding = 1'b0;
			end else begin
				out_stall <= !no_idle && ($urandom_range(0, 99) < 30);
				span = next_gap();
				if (span > 1)
					repeat (span - 1) @(posedge clk);
			end
		end
	end

	// Compare each accepted result beat with the oldest expectation.
	always @(posedge clk) begin : pad_checker
		rhpq_pkg::out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pad_expect_q.size() == 0) begin
				$error("unexpected result beat: pad_code %0d match_kind %0d",
					out_data.pad_code, out_data.match_kind);
				mismatches++;
			end else begin
				want = pad_expect_q.pop_front();
				results_checked++;
				if (out_data.pad_code !== want.pad_code) begin
					$error("pad_code: expected %0d, actual %0d",
						want.pad_code, out_data.pad_code);
					mismatches++;
				end
				if (out_data.match_kind !== want.match_kind) begin
					$error("match_kind: expected %0d, actual %0d",
						want.match_kind, out_data.match_kind);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				CYCLE_LIMIT, pad_expect_q.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : run
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_corner_colours();
		test_saturated_registers();
		test_random_settings();
		test_streaming();
		test_output_hold_off();

		// Let any stray beat show up before judging.
		wait_drained();
		repeat (PIPE_DEPTH + 8) @(posedge clk);

		$display("Sent %0d colour beats under %0d register settings, checked %0d results.",
			colours_sent, settings_loaded, results_checked);
		$display("Input was held back for %0d cycles by output back-pressure; %0d mismatches.",
			input_stall_cycles, mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
